// File: rtl/core/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg: shared types and constants of the multi-switch debouncer
// Holds the switch mode encoding, the per-switch state entry, the step result
// and the configuration register indexes.
// ----------------------------------------------------------------------------
package msd_pkg;

   localparam int MSD_NUM_SWITCHES = 16;

   localparam int INDEX_W   = 5;
   localparam int RUN_W     = 8;
   localparam int LEVELS_W  = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_COUNT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LEVELS = 1'b1;

   localparam logic [RUN_W-1:0]    SETTLE_COUNT_RESET  = 8'd10;
   localparam logic [LEVELS_W-1:0] ACTIVE_LEVELS_RESET = 16'h0000;

   typedef enum logic [1:0] {
      MODE_RELEASED = 2'd0,
      MODE_BOUNCING = 2'd1,
      MODE_PRESSED  = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type         mode;
      logic [RUN_W-1:0] active_run;
      logic [RUN_W-1:0] inactive_run;
      logic             reported_level;
   } entry_type;

   typedef struct packed {
      logic level_valid;
      logic pressed_level;
   } step_out_type;

   typedef struct packed {
      logic pressed_level;
      logic level_valid;
      logic status;
   } result_type;

endpackage

// File: rtl/core/multi_switch_debouncer.sv
// ----------------------------------------------------------------------------
// multi_switch_debouncer: counter-based debouncer for a bank of switches
//
//   channel   direction  payload (lowest bit first)
//   req_      in         tdata: switch_index[4:0], pin_level, 2 zero bits
//   rsp_      out        tdata: status, level_valid, pressed_level, 5 zero bits
//   csr_      in         write enable, register index, write data
//
// One beat is accepted every cycle while the input register can move on. A
// beat waits in the input register, where the switch entry is read, updated
// and written back, and its result is loaded into the output register when
// the beat moves on, from where the result beat is offered. A stalled
// output register blocks the input register only when both are full.
// Reset is synchronous and puts every switch in released mode.
// ----------------------------------------------------------------------------
module multi_switch_debouncer
   import msd_pkg::*;
#(
   parameter int NUM_SWITCHES = MSD_NUM_SWITCHES
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // switch_index[4:0], pin_level[5]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // status[0], level_valid[1], pressed_level[2]
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ROW_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

   logic [RUN_W-1:0]    settle_ff, settle_in;
   logic [LEVELS_W-1:0] levels_ff, levels_in;

   logic                s1_valid_ff, s1_valid_in;
   logic [INDEX_W-1:0]  s1_index_ff;
   logic                s1_pin_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_data_ff, rsp_data_in;

   entry_type           entry_ff [NUM_SWITCHES];

   logic                s1_advance;
   logic                in_range;
   logic [ROW_W-1:0]    row;
   logic                act_lvl;
   logic                active;
   entry_type           cur_entry;
   entry_type           nxt_entry;
   step_out_type        step_out;

   // Configuration registers.
   always_comb begin
      settle_in = settle_ff;
      levels_in = levels_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SETTLE_COUNT:  settle_in = csr_wdata[RUN_W-1:0];
            CSR_ACTIVE_LEVELS: levels_in = csr_wdata[LEVELS_W-1:0];
            default: begin
               settle_in = settle_ff;
               levels_in = levels_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_COUNT_RESET;
         levels_ff <= ACTIVE_LEVELS_RESET;
      end else begin
         settle_ff <= settle_in;
         levels_ff <= levels_in;
      end
   end

   // Handshake: the input register moves on whenever the output register
   // is empty or being drained.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;

   assign s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_index_ff <= req_tdata[INDEX_W-1:0];
         s1_pin_ff   <= req_tdata[INDEX_W];
      end
      rsp_data_ff <= rsp_data_in;
   end

   // Switch lookup and update.
   assign in_range  = {1'b0, s1_index_ff} < (INDEX_W + 1)'(NUM_SWITCHES);
   assign row       = s1_index_ff[ROW_W-1:0];
   assign cur_entry = entry_ff[row];
   // Only the first sixteen switches have an active-level bit.
   assign act_lvl   = s1_index_ff[4] ? 1'b0 : levels_ff[s1_index_ff[3:0]];
   assign active    = (s1_pin_ff == act_lvl);

   msd_step u_step (
      .cur_entry    (cur_entry),
      .active       (active),
      .settle_count (settle_ff),
      .nxt_entry    (nxt_entry),
      .step_out     (step_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SWITCHES; i++) begin
            entry_ff[i] <= '{mode: MODE_RELEASED, default: '0};
         end
      end else if (s1_advance && in_range) begin
         entry_ff[row] <= nxt_entry;
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (s1_advance) begin
         rsp_data_in.status        = !in_range;
         rsp_data_in.level_valid   = in_range && step_out.level_valid;
         rsp_data_in.pressed_level = in_range && step_out.pressed_level;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_data_ff};

endmodule

// File: rtl/core/msd_step.sv
// ----------------------------------------------------------------------------
// msd_step: next-state logic for one switch poll
// Takes the current state entry of one switch and whether the sampled pin is
// at its active level, and returns the updated entry and the reported level.
// ----------------------------------------------------------------------------
module msd_step
   import msd_pkg::*;
(
   input  entry_type        cur_entry,
   input  logic             active,
   input  logic [RUN_W-1:0] settle_count,
   output entry_type        nxt_entry,
   output step_out_type     step_out
);

   // Run counters stop at the threshold, so they never wrap.
   function automatic logic [RUN_W-1:0] bump(input logic [RUN_W-1:0] run,
                                             input logic [RUN_W-1:0] limit);
      bump = (run < limit) ? run + 1'b1 : run;
   endfunction

   always_comb begin
      nxt_entry = cur_entry;
      step_out  = '0;
      unique case (cur_entry.mode)
         MODE_RELEASED: begin
            if (active) begin
               nxt_entry.mode         = MODE_BOUNCING;
               nxt_entry.inactive_run = '0;
            end else begin
               nxt_entry.reported_level = 1'b0;
            end
            step_out.level_valid   = 1'b1;
            step_out.pressed_level = nxt_entry.reported_level;
         end
         MODE_BOUNCING: begin
            if (active) begin
               nxt_entry.active_run   = bump(cur_entry.active_run, settle_count);
               nxt_entry.inactive_run = '0;
            end else begin
               nxt_entry.inactive_run = bump(cur_entry.inactive_run, settle_count);
               nxt_entry.active_run   = '0;
            end
            // The released check comes last and wins when both runs qualify.
            if (nxt_entry.active_run >= settle_count) begin
               nxt_entry.mode = MODE_PRESSED;
            end
            if (nxt_entry.inactive_run >= settle_count) begin
               nxt_entry.mode = MODE_RELEASED;
            end
         end
         MODE_PRESSED: begin
            if (!active) begin
               nxt_entry.active_run = '0;
               nxt_entry.mode       = MODE_BOUNCING;
            end else begin
               nxt_entry.reported_level = 1'b1;
            end
            step_out.level_valid   = 1'b1;
            step_out.pressed_level = nxt_entry.reported_level;
         end
         default: begin
            nxt_entry = cur_entry;
            step_out  = '0;
         end
      endcase
   end

endmodule

// File: rtl/core/msd_checker.sv
// ----------------------------------------------------------------------------
// msd_checker: port-level checks of the multi-switch debouncer
// Watches the result channel and checks output consistency and reset.
// ----------------------------------------------------------------------------
module msd_checker
   import msd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // A stalled result beat stays and keeps its payload.
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result beat dropped or changed");

   // An out-of-range index never reports a level.
   property p_error_no_level;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && rsp_tdata[0] |-> (rsp_tdata[2:1] == 2'b00);
   endproperty
   a_error_no_level: assert property (p_error_no_level)
      else $error("error beat carries a level");

   // A pressed level is only shown together with its valid flag.
   property p_level_needs_valid;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1];
   endproperty
   a_level_needs_valid: assert property (p_level_needs_valid)
      else $error("pressed level without valid flag");

   // No result is offered in the cycle after reset.
   property p_reset_empty;
      @(posedge clock) $past(reset) |-> !rsp_tvalid;
   endproperty
   a_reset_empty: assert property (p_reset_empty) else $error("result valid after reset");

endmodule

bind multi_switch_debouncer msd_checker u_msd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: test/multi_switch_debouncer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_switch_debouncer_test: self-checking bench for the switch debouncer
// Polls switches through the request stream and checks every response beat
// against a behavioral debounce model kept in the bench or a typed result.
// A short directed table covers reset behavior, range errors, saturation and
// the zero and full-scale thresholds. It is followed by random press and
// release episodes with bounce noise under a range of settle counts and
// active-level masks. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module multi_switch_debouncer_test;
   import msd_pkg::*;

   localparam int   ITEM_TARGET   = 1500;
   localparam int   PHASE_ITEMS   = 120;
   localparam int   QUIET_ITEMS   = 150;
   localparam int   DRAIN_CYCLES  = 4;
   localparam int   CYCLE_LIMIT   = 400000;
   localparam int   MAX_PRINTED   = 50;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   localparam result_type RES_RANGE_ERR =
      '{pressed_level: 1'b0, level_valid: 1'b0, status: STATUS_RANGE};
   localparam result_type RES_LEVEL_LOW =
      '{pressed_level: 1'b0, level_valid: 1'b1, status: STATUS_OK};
   localparam result_type RES_BOUNCING =
      '{pressed_level: 1'b0, level_valid: 1'b0, status: STATUS_OK};

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [INDEX_W-1:0]     idx;
      logic                   pin;
      bit                     typed;
      result_type             want;
      logic [CSR_IDX_W-1:0]   csr_sel;
      logic [CSR_DATA_W-1:0]  csr_value;
   } step_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [7:0]             rsp_tdata;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Bench copy of the debouncer state and configuration.
   mode_type               sw_mode   [MSD_NUM_SWITCHES];
   logic [RUN_W-1:0]       act_run   [MSD_NUM_SWITCHES];
   logic [RUN_W-1:0]       inact_run [MSD_NUM_SWITCHES];
   logic                   sw_level  [MSD_NUM_SWITCHES];
   logic [RUN_W-1:0]       cfg_settle;
   logic [LEVELS_W-1:0]    cfg_levels;

   result_type             pending_results[$];
   step_row_type           directed_rows[$];
   int                     items_sent;
   int                     errors;
   int                     cycles;
   int                     stall_left;
   bit                     idle_on;

   multi_switch_debouncer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Debounce one poll and return the response it should produce.
   function automatic result_type debounce_step(logic [INDEX_W-1:0] idx, logic pin);
      result_type res;
      logic       active;
      int         s;
      res = RES_BOUNCING;
      if (int'(idx) >= MSD_NUM_SWITCHES) begin
         return RES_RANGE_ERR;
      end
      s = int'(idx);
      active = (pin == cfg_levels[s]);
      case (sw_mode[s])
         MODE_RELEASED: begin
            if (active) begin
               sw_mode[s] = MODE_BOUNCING;
               inact_run[s] = '0;
            end else begin
               sw_level[s] = 1'b0;
            end
            res.level_valid = 1'b1;
            res.pressed_level = sw_level[s];
         end
         MODE_BOUNCING: begin
            if (active) begin
               if (act_run[s] < cfg_settle) act_run[s] = act_run[s] + 1'b1;
               inact_run[s] = '0;
            end else begin
               if (inact_run[s] < cfg_settle) inact_run[s] = inact_run[s] + 1'b1;
               act_run[s] = '0;
            end
            // The released check comes last and wins when both runs qualify.
            if (act_run[s] >= cfg_settle) sw_mode[s] = MODE_PRESSED;
            if (inact_run[s] >= cfg_settle) sw_mode[s] = MODE_RELEASED;
         end
         MODE_PRESSED: begin
            if (!active) begin
               act_run[s] = '0;
               sw_mode[s] = MODE_BOUNCING;
            end else begin
               sw_level[s] = 1'b1;
            end
            res.level_valid = 1'b1;
            res.pressed_level = sw_level[s];
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic step_row_type row_sample(logic [INDEX_W-1:0] idx, logic pin,
                                               bit typed, result_type want);
      step_row_type r;
      r = '{kind: ROW_SAMPLE, idx: idx, pin: pin, typed: typed, want: want,
            csr_sel: CSR_SETTLE_COUNT, csr_value: '0};
      return r;
   endfunction

   function automatic step_row_type row_write(logic [CSR_IDX_W-1:0] sel,
                                              logic [CSR_DATA_W-1:0] value);
      step_row_type r;
      r = '{kind: ROW_WRITE, idx: '0, pin: 1'b0, typed: 1'b0, want: RES_BOUNCING,
            csr_sel: sel, csr_value: value};
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      if (errors < MAX_PRINTED)
         $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   task automatic check_result(logic [7:0] data);
      result_type got;
      result_type want;
      got = result_type'(data[2:0]);
      if (pending_results.size() == 0) begin
         report_mismatch("response beat with no poll pending", data, 8'd0);
      end else begin
         want = pending_results.pop_front();
         if (got.status !== want.status)
            report_mismatch("status", 8'(got.status), 8'(want.status));
         if (got.level_valid !== want.level_valid)
            report_mismatch("level_valid", 8'(got.level_valid), 8'(want.level_valid));
         if (got.pressed_level !== want.pressed_level)
            report_mismatch("pressed_level", 8'(got.pressed_level),
                            8'(want.pressed_level));
         if (data[7:3] !== 5'd0)
            report_mismatch("tdata padding", 8'(data[7:3]), 8'd0);
      end
   endtask

   // Response side: check accepted beats and throttle tready in bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Called right after a rising edge; returns at the edge that took the beat.
   task automatic send_sample(logic [INDEX_W-1:0] idx, logic pin, bit typed,
                              result_type want);
      result_type predicted;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, pin, idx};
      do @(posedge clock); while (!req_tready);
      predicted = debounce_step(idx, pin);
      pending_results.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] sel, logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (sel == CSR_SETTLE_COUNT) cfg_settle = value[RUN_W-1:0];
      else cfg_levels = value[LEVELS_W-1:0];
      @(posedge clock);
   endtask

   // Random poll with occasional extra polls of random switch indexes mixed in.
   task automatic poll(logic [INDEX_W-1:0] idx, logic pin);
      send_sample(idx, pin, 1'b0, RES_BOUNCING);
      if ($urandom_range(0, 9) == 0)
         send_sample(INDEX_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                     1'b0, RES_BOUNCING);
   endtask

   // One press and release of a switch, framed by bounce noise. Some episodes
   // break it off before it settles; others poll only out-of-range indexes.
   task automatic play_episode();
      logic [INDEX_W-1:0] idx;
      logic               on_pin;
      int                 press_len;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 3))
            poll(INDEX_W'($urandom_range(MSD_NUM_SWITCHES, 31)), 1'($urandom_range(0, 1)));
      end else begin
         idx = INDEX_W'($urandom_range(0, MSD_NUM_SWITCHES - 1));
         on_pin = cfg_levels[idx];
         if ($urandom_range(0, 4) == 0) press_len = $urandom_range(0, cfg_settle);
         else press_len = int'(cfg_settle) + $urandom_range(0, 2);
         repeat ($urandom_range(0, 4)) poll(idx, 1'($urandom_range(0, 1)));
         repeat (press_len) poll(idx, on_pin);
         repeat ($urandom_range(1, 4)) poll(idx, on_pin);
         repeat ($urandom_range(0, 4)) poll(idx, 1'($urandom_range(0, 1)));
         repeat (int'(cfg_settle) + $urandom_range(0, 2)) poll(idx, ~on_pin);
         repeat ($urandom_range(1, 3)) poll(idx, ~on_pin);
      end
   endtask

   initial begin
      int           phase;
      int           phase_start;
      int           pick;
      step_row_type row;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_SETTLE_COUNT;
      csr_wdata = '0;
      items_sent = 0;
      errors = 0;
      cycles = 0;
      stall_left = 0;
      idle_on = 1'b1;
      cfg_settle = SETTLE_COUNT_RESET;
      cfg_levels = ACTIVE_LEVELS_RESET;
      for (int s = 0; s < MSD_NUM_SWITCHES; s++) begin
         sw_mode[s] = MODE_RELEASED;
         act_run[s] = '0;
         inact_run[s] = '0;
         sw_level[s] = 1'b0;
      end

      // At reset every switch is released and a low pin is the active level.
      directed_rows.push_back(row_sample(5'd0,  1'b1, 1'b1, RES_LEVEL_LOW));
      directed_rows.push_back(row_sample(5'd31, 1'b0, 1'b1, RES_RANGE_ERR));
      directed_rows.push_back(row_sample(5'd16, 1'b1, 1'b1, RES_RANGE_ERR));
      directed_rows.push_back(row_sample(5'd15, 1'b0, 1'b1, RES_LEVEL_LOW));
      directed_rows.push_back(row_sample(5'd15, 1'b0, 1'b1, RES_BOUNCING));
      directed_rows.push_back(row_sample(5'd15, 1'b1, 1'b0, RES_BOUNCING));
      directed_rows.push_back(row_write(CSR_SETTLE_COUNT, 16'd1));
      directed_rows.push_back(row_write(CSR_ACTIVE_LEVELS, 16'hFFFF));
      directed_rows.push_back(row_sample(5'd3, 1'b1, 1'b0, RES_BOUNCING));
      directed_rows.push_back(row_sample(5'd3, 1'b1, 1'b0, RES_BOUNCING));
      directed_rows.push_back(row_sample(5'd3, 1'b1, 1'b0, RES_BOUNCING));
      directed_rows.push_back(row_sample(5'd3, 1'b0, 1'b0, RES_BOUNCING));
      directed_rows.push_back(row_sample(5'd3, 1'b0, 1'b0, RES_BOUNCING));
      directed_rows.push_back(row_sample(5'd3, 1'b0, 1'b0, RES_BOUNCING));
      // Switch 15 has a run already at the new threshold, so it must not count on.
      directed_rows.push_back(row_sample(5'd15, 1'b0, 1'b0, RES_BOUNCING));
      // With a zero threshold both runs qualify at once and released wins.
      directed_rows.push_back(row_write(CSR_SETTLE_COUNT, 16'd0));
      directed_rows.push_back(row_sample(5'd7, 1'b1, 1'b0, RES_BOUNCING));
      directed_rows.push_back(row_sample(5'd7, 1'b1, 1'b0, RES_BOUNCING));
      directed_rows.push_back(row_sample(5'd7, 1'b0, 1'b0, RES_BOUNCING));
      directed_rows.push_back(row_write(CSR_SETTLE_COUNT, 16'd255));
      directed_rows.push_back(row_write(CSR_ACTIVE_LEVELS, 16'h0000));
      directed_rows.push_back(row_sample(5'd15, 1'b0, 1'b0, RES_BOUNCING));
      directed_rows.push_back(row_sample(5'd15, 1'b1, 1'b0, RES_BOUNCING));
      directed_rows.push_back(row_sample(5'd31, 1'b1, 1'b1, RES_RANGE_ERR));
      directed_rows.push_back(row_sample(5'd0,  1'b0, 1'b0, RES_BOUNCING));
      directed_rows.push_back(row_sample(5'd0,  1'b0, 1'b0, RES_BOUNCING));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE) begin
            wait_idle();
            csr_write(row.csr_sel, row.csr_value);
         end else begin
            send_sample(row.idx, row.pin, row.typed, row.want);
         end
      end

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         if (phase == 0) begin
            csr_write(CSR_SETTLE_COUNT, 16'd1);
            csr_write(CSR_ACTIVE_LEVELS, 16'hFFFF);
         end else if (phase == 1) begin
            csr_write(CSR_SETTLE_COUNT, 16'd255);
            csr_write(CSR_ACTIVE_LEVELS, 16'h0000);
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 6) csr_write(CSR_SETTLE_COUNT, 16'($urandom_range(1, 6)));
            else if (pick < 9) csr_write(CSR_SETTLE_COUNT, 16'($urandom_range(7, 24)));
            else csr_write(CSR_SETTLE_COUNT, 16'($urandom_range(25, 60)));
            csr_write(CSR_ACTIVE_LEVELS, 16'($urandom_range(0, 65535)));
         end
         // The closing stretch of the run has no idling on either side.
         if (items_sent >= ITEM_TARGET - QUIET_ITEMS) idle_on = 1'b0;
         else idle_on = ($urandom_range(0, 3) != 0);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) play_episode();
         phase++;
      end

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
